>>> hdl/oltt_pkg.sv
// ----------------------------------------------------------------------------
// oltt_pkg
// Shared types, constants and helpers of the outstanding request tracker.
// ----------------------------------------------------------------------------
package oltt_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 5;

	// table entry layout: {warned, elapsed, id}
	localparam int ID_W    = 32;
	localparam int TIME_W  = 32;
	localparam int TOTAL_W = 48;
	localparam int ENTRY_W = 1 + TIME_W + ID_W;

	// request function codes
	localparam logic [2:0] FUNC_TICK     = 3'd0;
	localparam logic [2:0] FUNC_BEGIN    = 3'd1;
	localparam logic [2:0] FUNC_COMPLETE = 3'd2;
	localparam logic [2:0] FUNC_FAIL     = 3'd3;
	localparam logic [2:0] FUNC_STATUS   = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_WARN   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_WARN_THR  = 2'd1;
	localparam logic [1:0] REG_STALL_THR = 2'd2;
	localparam logic [1:0] REG_MAX_CONC  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_APPLY,
		ST_DIV,
		ST_RESP,
		ST_WRD,
		ST_WLD
	} state_t;

	// lowest clear bit; returns 0 when none is clear
	function automatic logic [IDX_W-1:0] first_zero(input logic [TABLE_DEPTH-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

	// lowest set bit; returns 0 when none is set
	function automatic logic [IDX_W-1:0] first_one(input logic [TABLE_DEPTH-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

endpackage

>>> hdl/oltt_ram.sv
// ----------------------------------------------------------------------------
// oltt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module oltt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/oltt_div.sv
// ----------------------------------------------------------------------------
// oltt_div
// Restoring divider, one quotient bit per cycle: 48-bit total time over the
// 32-bit finish count, quotient saturated to 32 bits, zero when count is zero.
// ----------------------------------------------------------------------------
module oltt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [oltt_pkg::TOTAL_W-1:0]  num,
	input  logic [oltt_pkg::TIME_W-1:0]   den,
	output logic                          done,
	output logic [oltt_pkg::TIME_W-1:0]   quo
);
	import oltt_pkg::*;

	localparam int STEP_W = $clog2(TOTAL_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic [TOTAL_W-1:0]   n_q;
	logic [TIME_W:0]      rem_q;
	logic [TIME_W-1:0]    den_q;
	logic [TIME_W:0]      rem_sh;
	logic                 qbit;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q[TIME_W-1:0], n_q[TOTAL_W-1]};
		qbit   = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(TOTAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
			n_q   <= {n_q[TOTAL_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = (den_q == '0) ? '0 :
	              (|n_q[TOTAL_W-1:TIME_W]) ? {TIME_W{1'b1}} : n_q[TIME_W-1:0];

endmodule

>>> hdl/outstanding_load_timeout_tracker_unit.sv
// ----------------------------------------------------------------------------
// outstanding_load_timeout_tracker_unit
// Table of outstanding requests with elapsed-time tracking and statistics.
// ----------------------------------------------------------------------------
// One request is handled at a time. Each request walks all TABLE_DEPTH table
// entries through the single read port of the entry RAM, one entry a cycle.
// A complete or fail that matches an entry also runs the bit-serial average
// divider. A tick that reports warnings emits one result per warning, each a
// RAM read then an output load, in place of the single response, and waits
// while the output side stalls. The input stall is high while a request is in
// work; the output register lets the next request in while a result waits.
// ----------------------------------------------------------------------------
module outstanding_load_timeout_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [15:0] tick_amount,
	input  logic [31:0] load_id,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] result_id,
	output logic        found,
	output logic [4:0]  active_count,
	output logic [4:0]  stalled_count,
	output logic [31:0] completed_count,
	output logic [31:0] failed_count,
	output logic [31:0] worst_time,
	output logic [31:0] average_time,
	output logic [31:0] overflow_count,
	output logic        last
);
	import oltt_pkg::*;

	// configuration registers
	logic              enable_q;
	logic [TIME_W-1:0] warn_thr_q;
	logic [TIME_W-1:0] stall_thr_q;
	logic [4:0]        max_conc_q;

	// request latched at accept
	logic [2:0]  func_q;
	logic [15:0] amount_q;
	logic [31:0] id_q;

	// control state
	state_t                 state_q, state_d;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] newwarn_q;
	logic [IDX_W-1:0]       iss_q;
	logic                   iss_on_q;
	logic                   act_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [IDX_W-1:0]       warn_idx_q;

	// statistics
	logic [CNT_W-1:0]   active_q;
	logic [CNT_W-1:0]   stall_acc_q;
	logic [CNT_W-1:0]   stalled_q;
	logic [ID_W-1:0]    next_id_q;
	logic [31:0]        ok_q;
	logic [31:0]        fail_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TIME_W-1:0]  worst_q;
	logic [TIME_W-1:0]  avg_q;
	logic [31:0]        ovf_q;

	// match found during the walk
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [TIME_W-1:0] hit_el_q;
	logic              hit_stall_q;

	// response of the request
	logic [1:0]  rsp_kind_q;
	logic [31:0] rsp_id_q;
	logic        rsp_found_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [31:0] res_id_q;
	logic        found_q;
	logic        last_q;
	logic [4:0]  o_active_q;
	logic [4:0]  o_stalled_q;
	logic [31:0] o_ok_q;
	logic [31:0] o_fail_q;
	logic [31:0] o_worst_q;
	logic [31:0] o_avg_q;
	logic [31:0] o_ovf_q;

	// RAM port
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// divider
	logic               div_start;
	logic               div_done;
	logic [TIME_W-1:0]  div_quo;

	logic in_acc;
	logic out_free;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	oltt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// entry fields at walk stage 1
	logic [ID_W-1:0]    e_id;
	logic [TIME_W-1:0]  e_el;
	logic               e_warned;
	logic               tick_en;
	logic [TIME_W:0]    el_sum;
	logic [TIME_W-1:0]  el_new;
	logic               warn_new;
	logic               e_valid;
	logic               e_stalled;

	assign e_id     = ram_rdata[ID_W-1:0];
	assign e_el     = ram_rdata[ID_W+TIME_W-1:ID_W];
	assign e_warned = ram_rdata[ENTRY_W-1];
	assign tick_en  = (func_q == FUNC_TICK) && enable_q;
	assign e_valid  = valid_q[idx_s1];

	// saturating elapsed update and warning check
	always_comb begin
		el_sum    = {1'b0, e_el} + {{(TIME_W+1-16){1'b0}}, amount_q};
		el_new    = tick_en ? (el_sum[TIME_W] ? {TIME_W{1'b1}} : el_sum[TIME_W-1:0]) : e_el;
		warn_new  = tick_en && !e_warned && (el_new >= warn_thr_q);
		e_stalled = e_valid && (el_new >= stall_thr_q);
	end

	// apply-stage values
	logic               is_begin, is_finish;
	logic               begin_ok;
	logic [IDX_W-1:0]   free_idx;
	logic [CNT_W:0]     active_inc;
	logic [TOTAL_W:0]   total_sum;
	logic [TOTAL_W-1:0] total_new;
	logic [31:0]        ok_new, fail_new, fin_new;
	logic [ID_W-1:0]    next_id_inc;

	always_comb begin
		is_begin    = (func_q == FUNC_BEGIN);
		is_finish   = (func_q == FUNC_COMPLETE) || (func_q == FUNC_FAIL);
		free_idx    = first_zero(valid_q);
		begin_ok    = is_begin && enable_q && !(&valid_q);
		active_inc  = {1'b0, active_q} + 1'b1;
		total_sum   = {1'b0, total_q} + {{(TOTAL_W+1-TIME_W){1'b0}}, hit_el_q};
		total_new   = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
		ok_new      = ok_q + {31'd0, (func_q == FUNC_COMPLETE)};
		fail_new    = fail_q + {31'd0, (func_q == FUNC_FAIL)};
		fin_new     = ok_new + fail_new;
		next_id_inc = next_id_q + 1'b1;
		if (next_id_inc == '0) next_id_inc = ID_W'(1);
	end

	assign div_start = (state_q == ST_APPLY) && is_finish && hit_q;

	oltt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (total_new),
		.den    (fin_new),
		.done   (div_done),
		.quo    (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc) state_d = ST_WALK;
			ST_WALK:  if (act_s1 && idx_s1 == IDX_W'(TABLE_DEPTH - 1)) state_d = ST_APPLY;
			ST_APPLY: begin
				if (is_finish && hit_q) state_d = ST_DIV;
				else if (func_q == FUNC_TICK && newwarn_q != '0) state_d = ST_WRD;
				else state_d = ST_RESP;
			end
			ST_DIV:   if (div_done) state_d = ST_RESP;
			ST_RESP:  if (out_free) state_d = ST_IDLE;
			ST_WRD:   state_d = ST_WLD;
			ST_WLD: begin
				if (out_free) begin
					if ((newwarn_q & ~(TABLE_DEPTH'(1) << warn_idx_q)) != '0) state_d = ST_WRD;
					else state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = iss_q;
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = {warn_new | e_warned, el_new, e_id};
		unique case (state_q)
			ST_WALK: begin
				ram_re = iss_on_q;
				ram_we = act_s1 && tick_en && e_valid;
			end
			ST_APPLY: begin
				ram_we    = begin_ok;
				ram_waddr = free_idx;
				ram_wdata = {1'b0, {TIME_W{1'b0}}, next_id_q};
			end
			ST_WRD: begin
				ram_re    = 1'b1;
				ram_raddr = first_one(newwarn_q);
			end
			default: ;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b1;
			warn_thr_q  <= 32'd5000;
			stall_thr_q <= 32'd10000;
			max_conc_q  <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:    enable_q    <= cfg_data[0];
				REG_WARN_THR:  warn_thr_q  <= cfg_data;
				REG_STALL_THR: stall_thr_q <= cfg_data;
				REG_MAX_CONC:  max_conc_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q   <= func;
			amount_q <= tick_amount;
			id_q     <= load_id;
		end
	end

	// control and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			newwarn_q   <= '0;
			iss_q       <= '0;
			iss_on_q    <= 1'b0;
			act_s1      <= 1'b0;
			idx_s1      <= '0;
			warn_idx_q  <= '0;
			active_q    <= '0;
			stall_acc_q <= '0;
			stalled_q   <= '0;
			next_id_q   <= ID_W'(1);
			ok_q        <= '0;
			fail_q      <= '0;
			total_q     <= '0;
			worst_q     <= '0;
			avg_q       <= '0;
			ovf_q       <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// walk issue and stage 1
			act_s1 <= (state_q == ST_WALK) && iss_on_q;
			idx_s1 <= iss_q;
			if (in_acc) begin
				iss_q       <= '0;
				iss_on_q    <= 1'b1;
				stall_acc_q <= '0;
				hit_q       <= 1'b0;
				newwarn_q   <= '0;
			end else if (state_q == ST_WALK && iss_on_q) begin
				iss_q <= iss_q + 1'b1;
				if (iss_q == IDX_W'(TABLE_DEPTH - 1)) iss_on_q <= 1'b0;
			end

			// per-entry processing
			if (state_q == ST_WALK && act_s1) begin
				if (e_stalled) stall_acc_q <= stall_acc_q + 1'b1;
				if (warn_new && e_valid) newwarn_q[idx_s1] <= 1'b1;
				if (is_finish && !hit_q && e_valid && e_id == id_q) begin
					hit_q <= 1'b1;
				end
			end

			// fold the request into the table and statistics
			if (state_q == ST_APPLY) begin
				stalled_q <= stall_acc_q
				           + {{(CNT_W-1){1'b0}}, begin_ok && (stall_thr_q == '0)}
				           - {{(CNT_W-1){1'b0}}, is_finish && hit_q && hit_stall_q};
				if (begin_ok) begin
					valid_q[free_idx] <= 1'b1;
					active_q          <= active_inc[CNT_W-1:0];
					next_id_q         <= next_id_inc;
					if (active_inc > {1'b0, max_conc_q}) ovf_q <= ovf_q + 1'b1;
				end
				if (is_finish && hit_q) begin
					valid_q[hit_idx_q] <= 1'b0;
					active_q           <= active_q - 1'b1;
					total_q            <= total_new;
					ok_q               <= ok_new;
					fail_q             <= fail_new;
					if (hit_el_q > worst_q) worst_q <= hit_el_q;
				end
			end

			if (state_q == ST_DIV && div_done) avg_q <= div_quo;

			// warning emission bookkeeping
			if (state_q == ST_WRD) warn_idx_q <= first_one(newwarn_q);
			if (state_q == ST_WLD && out_free) newwarn_q[warn_idx_q] <= 1'b0;

			// output register valid
			if ((state_q == ST_RESP || state_q == ST_WLD) && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	// match capture and response payload
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && act_s1 && is_finish && !hit_q && e_valid && e_id == id_q) begin
			hit_idx_q   <= idx_s1;
			hit_el_q    <= e_el;
			hit_stall_q <= e_stalled;
		end
		if (state_q == ST_APPLY) begin
			rsp_kind_q  <= (func_q == FUNC_STATUS) ? KIND_STATUS : KIND_ACK;
			rsp_id_q    <= begin_ok ? next_id_q : 32'd0;
			rsp_found_q <= begin_ok || (is_finish && hit_q);
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_RESP || state_q == ST_WLD) && out_free) begin
			if (state_q == ST_WLD) begin
				kind_q   <= KIND_WARN;
				res_id_q <= ram_rdata[ID_W-1:0];
				found_q  <= 1'b0;
				last_q   <= ((newwarn_q & ~(TABLE_DEPTH'(1) << warn_idx_q)) == '0);
			end else begin
				kind_q   <= rsp_kind_q;
				res_id_q <= rsp_id_q;
				found_q  <= rsp_found_q;
				last_q   <= 1'b1;
			end
			o_active_q  <= active_q;
			o_stalled_q <= stalled_q;
			o_ok_q      <= ok_q;
			o_fail_q    <= fail_q;
			o_worst_q   <= worst_q;
			o_avg_q     <= avg_q;
			o_ovf_q     <= ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign result_id       = res_id_q;
	assign found           = found_q;
	assign active_count    = o_active_q;
	assign stalled_count   = o_stalled_q;
	assign completed_count = o_ok_q;
	assign failed_count    = o_fail_q;
	assign worst_time      = o_worst_q;
	assign average_time    = o_avg_q;
	assign overflow_count  = o_ovf_q;
	assign last            = last_q;

endmodule
